FILE: design/eyvm_pkg.sv
// eyvm_pkg: shared types, constants and fixed-point helpers for the view matrix block.
// Used by eyvm_sincos, eyvm_lane and euler_yxz_view_matrix; no dependencies.
package eyvm_pkg;

	localparam int unsigned ANG_W = 16;
	localparam int unsigned Q_W = 32;
	localparam logic [33:0] PI_Q32 = 34'h3243F6A88;
	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] right_x;
		logic signed [31:0] right_y;
		logic signed [31:0] right_z;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
		logic signed [31:0] fwd_x;
		logic signed [31:0] fwd_y;
		logic signed [31:0] fwd_z;
		logic signed [31:0] shift_u;
		logic signed [31:0] shift_v;
		logic signed [31:0] shift_w;
	} out_beat_t;

	// Horner divisors, innermost first
	typedef logic [6:0] kvec_t [5];
	localparam kvec_t KS = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam kvec_t KC = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};

	// round p/2^30, ties away from zero
	function automatic logic signed [33:0] qrnd(input logic signed [63:0] p);
		logic [63:0] m;
		logic [63:0] r;
		begin
			m = p[63] ? 64'(-p) : 64'(p);
			r = (m + 64'(1 << 29)) >> 30;
			qrnd = p[63] ? -34'(r) : 34'(r);
		end
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		if (v > 34'sh0_4000_0000) clamp_unit = ONE_Q30;
		else if (v < -34'sh0_4000_0000) clamp_unit = -ONE_Q30;
		else clamp_unit = 32'(v);
	endfunction

endpackage

FILE: design/euler_yxz_view_matrix.sv
// euler_yxz_view_matrix: Y-X-Z view matrix and translation from camera pose.
// One item per cycle (busy stays low).
// Three sine/cosine pipelines feed three row lanes; the lanes share the output register.
// Reset clears only the valid shift line; payload registers are not reset.
// The receiver cannot stall: done pulses for one cycle per item.
module euler_yxz_view_matrix (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  eyvm_pkg::in_beat_t din,
	output logic done,
	output eyvm_pkg::out_beat_t dout
);
	import eyvm_pkg::*;
	localparam int unsigned SC_LAT = 13;
	localparam int unsigned LAT = SC_LAT + 4;

	assign busy = 1'b0;

	logic signed [31:0] s1, c1, s2, c2, s3, c3;
	eyvm_sincos u_sc1 (.clk, .ang(din.yaw), .sn(s1), .cs(c1));
	eyvm_sincos u_sc2 (.clk, .ang(din.pitch), .sn(s2), .cs(c2));
	eyvm_sincos u_sc3 (.clk, .ang(din.roll), .sn(s3), .cs(c3));

	// position delay to align with trig
	logic signed [31:0] pd [SC_LAT][3];
	always_ff @(posedge clk) begin
		pd[0][0] <= din.pos_x; pd[0][1] <= din.pos_y; pd[0][2] <= din.pos_z;
		for (int i = 1; i < SC_LAT; i++) pd[i] <= pd[i-1];
	end

	logic signed [31:0] ru [3], rv [3], rw [3];
	logic signed [31:0] su, sv, sw;
	eyvm_lane u_lu (.clk, .a0(c1), .b0(c3), .c0(s1), .d0(s2), .e0(s3),
		.a1(c2), .b1(s3), .a2(c3), .b2(s1), .c2(c1), .d2(s2), .e2(s3), .sub(3'b100),
		.px(pd[SC_LAT-1][0]), .py(pd[SC_LAT-1][1]), .pz(pd[SC_LAT-1][2]), .row(ru), .shift(su));
	eyvm_lane u_lv (.clk, .a0(c1), .b0(s3), .c0(c3), .d0(s1), .e0(s2),
		.a1(c2), .b1(c3), .a2(s1), .b2(s3), .c2(c1), .d2(c3), .e2(s2), .sub(3'b001),
		.px(pd[SC_LAT-1][0]), .py(pd[SC_LAT-1][1]), .pz(pd[SC_LAT-1][2]), .row(rv), .shift(sv));
	// w: (c2*s1 + 0, -s2, c1*c2 + 0)
	eyvm_lane u_lw (.clk, .a0(c2), .b0(s1), .c0('0), .d0('0), .e0('0),
		.a1(s2), .b1('0), .a2(c1), .b2(c2), .c2('0), .d2('0), .e2('0), .sub(3'b010),
		.px(pd[SC_LAT-1][0]), .py(pd[SC_LAT-1][1]), .pz(pd[SC_LAT-1][2]), .row(rw), .shift(sw));

	// rows arrive in the cycle before the shift terms
	logic signed [31:0] ru_s1 [3], rv_s1 [3], rw_s1 [3];
	always_ff @(posedge clk) begin
		ru_s1 <= ru; rv_s1 <= rv; rw_s1 <= rw;
	end

	// merge into output beat
	always_ff @(posedge clk) begin
		dout <= '{ru_s1[0], ru_s1[1], ru_s1[2], rv_s1[0], rv_s1[1], rv_s1[2],
			rw_s1[0], rw_s1[1], rw_s1[2], su, sv, sw};
	end

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end
	assign done = vld_q[LAT-1];

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_q) <= LAT) else $error("valid line overflow");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("lost result");
	a_fwdy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (dout.fwd_y <= ONE_Q30 && dout.fwd_y >= -ONE_Q30))
		else $error("basis out of range");
endmodule

FILE: design/eyvm_sincos.sv
// eyvm_sincos: pipelined sine/cosine of a 16-bit binary angle, Q2.30 out.
// Depends on eyvm_pkg. One angle per cycle.
module eyvm_sincos (
	input  logic clk,
	input  logic [15:0] ang,
	output logic signed [31:0] sn,
	output logic signed [31:0] cs
);
	import eyvm_pkg::*;

	// stage 1: fold and scale to radians
	logic [1:0]  quad_s1;
	logic        fold_s1;
	logic [31:0] x_s1;
	logic [13:0] r;
	logic [14:0] rr;
	logic [48:0] xp;
	assign r = ang[13:0];
	assign rr = (r > 14'd8192) ? 15'(15'd16384 - 15'(r)) : 15'(r);
	assign xp = 49'(rr) * 49'(PI_Q32) + 49'(1 << 16);
	always_ff @(posedge clk) begin
		quad_s1 <= ang[15:14];
		fold_s1 <= r > 14'd8192;
		x_s1 <= 32'(xp >> 17);
	end

	// stage 2: x^2
	logic [1:0]  quad_s2;
	logic        fold_s2;
	logic [31:0] x_s2, x2_s2;
	logic [63:0] xx;
	assign xx = 64'(x_s1) * 64'(x_s1) + 64'(1 << 29);
	always_ff @(posedge clk) begin
		quad_s2 <= quad_s1;
		fold_s2 <= fold_s1;
		x_s2 <= x_s1;
		x2_s2 <= 32'(xx >> 30);
	end

	// Horner steps: two registers per step (multiply, then divide by constant
	// through a reciprocal multiply)
	logic [1:0]  quad_h [11];
	logic        fold_h [11];
	logic [31:0] x_h [11], x2_h [11], ts_h [11], tc_h [11];
	logic [63:0] ps_h [11], pc_h [11];
	assign quad_h[0] = quad_s2;
	assign fold_h[0] = fold_s2;
	assign x_h[0] = x_s2;
	assign x2_h[0] = x2_s2;
	assign ts_h[0] = 32'(ONE_Q30);
	assign tc_h[0] = 32'(ONE_Q30);
	assign ps_h[0] = '0;
	assign pc_h[0] = '0;

	for (genvar i = 0; i < 5; i++) begin : g_step
		// floor(a/k) == (a*RCP) >> SH for any a below 2^30
		localparam int unsigned SH_S = 30 + $clog2(int'(KS[i]));
		localparam int unsigned SH_C = 30 + $clog2(int'(KC[i]));
		localparam logic [31:0] RCP_S =
			32'(((64'd1 << SH_S) + 64'(KS[i]) - 64'd1) / 64'(KS[i]));
		localparam logic [31:0] RCP_C =
			32'(((64'd1 << SH_C) + 64'(KC[i]) - 64'd1) / 64'(KC[i]));
		logic [63:0] qs, qc;
		logic [29:0] as, ac;
		always_ff @(posedge clk) begin
			quad_h[2*i+1] <= quad_h[2*i];
			fold_h[2*i+1] <= fold_h[2*i];
			x_h[2*i+1] <= x_h[2*i];
			x2_h[2*i+1] <= x2_h[2*i];
			ts_h[2*i+1] <= ts_h[2*i];
			tc_h[2*i+1] <= tc_h[2*i];
			ps_h[2*i+1] <= 64'(x2_h[2*i]) * 64'(ts_h[2*i]);
			pc_h[2*i+1] <= 64'(x2_h[2*i]) * 64'(tc_h[2*i]);
		end
		// round(p / (k*2^30)): add half, drop 30 bits, then divide by k
		assign as = 30'((ps_h[2*i+1] + (64'(KS[i]) << 29)) >> 30);
		assign ac = 30'((pc_h[2*i+1] + (64'(KC[i]) << 29)) >> 30);
		assign qs = 64'((62'(as) * 62'(RCP_S)) >> SH_S);
		assign qc = 64'((62'(ac) * 62'(RCP_C)) >> SH_C);
		always_ff @(posedge clk) begin
			quad_h[2*i+2] <= quad_h[2*i+1];
			fold_h[2*i+2] <= fold_h[2*i+1];
			x_h[2*i+2] <= x_h[2*i+1];
			x2_h[2*i+2] <= x2_h[2*i+1];
			ts_h[2*i+2] <= (qs >= 64'(ONE_Q30)) ? '0 : 32'(64'(ONE_Q30) - qs);
			tc_h[2*i+2] <= (qc >= 64'(ONE_Q30)) ? '0 : 32'(64'(ONE_Q30) - qc);
			ps_h[2*i+2] <= '0;
			pc_h[2*i+2] <= '0;
		end
	end

	// final: sine = x*t, fold and quadrant rotate
	logic [63:0] sp;
	logic signed [31:0] s0, c0;
	assign sp = 64'(x_h[10]) * 64'(ts_h[10]) + 64'(1 << 29);
	assign s0 = fold_h[10] ? tc_h[10] : 32'(sp >> 30);
	assign c0 = fold_h[10] ? 32'(sp >> 30) : tc_h[10];
	always_ff @(posedge clk) begin
		unique case (quad_h[10])
			2'd0: begin sn <= s0; cs <= c0; end
			2'd1: begin sn <= c0; cs <= -s0; end
			2'd2: begin sn <= -s0; cs <= -c0; end
			default: begin sn <= -c0; cs <= s0; end
		endcase
	end
endmodule

FILE: design/eyvm_lane.sv
// eyvm_lane: one basis row lane; forms the row from trig products and its
// translation term. Depends on eyvm_pkg.
module eyvm_lane (
	input  logic clk,
	input  logic signed [31:0] a0, b0, c0, d0, e0,
	input  logic signed [31:0] a1, b1,
	input  logic signed [31:0] a2, b2, c2, d2, e2,
	input  logic [2:0] sub,
	input  logic signed [31:0] px, py, pz,
	output logic signed [31:0] row [3],
	output logic signed [31:0] shift
);
	import eyvm_pkg::*;
	// element k: a*b + (c*d)*e, or (c*d)*e - a*b ; element 1 uses a1*b1 only.
	// sub[0]: element 0 subtracts; sub[2]: element 2 subtracts
	// sub[1]: element 1 is -a1 (no product)
	logic signed [33:0] ab0_s1, cd0_s1, ab1_s1, ab2_s1, cd2_s1;
	logic signed [31:0] e0_s1, e2_s1, a1_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1, px_s2, py_s2, pz_s2;
	logic [2:0] sub_s1;
	always_ff @(posedge clk) begin
		ab0_s1 <= qrnd(64'(a0) * 64'(b0));
		cd0_s1 <= qrnd(64'(c0) * 64'(d0));
		ab1_s1 <= qrnd(64'(a1) * 64'(b1));
		ab2_s1 <= qrnd(64'(a2) * 64'(b2));
		cd2_s1 <= qrnd(64'(c2) * 64'(d2));
		e0_s1 <= e0; e2_s1 <= e2; a1_s1 <= a1; sub_s1 <= sub;
		px_s1 <= px; py_s1 <= py; pz_s1 <= pz;
	end
	logic signed [33:0] t0, t2;
	assign t0 = qrnd(64'(cd0_s1) * 64'(e0_s1));
	assign t2 = qrnd(64'(cd2_s1) * 64'(e2_s1));
	always_ff @(posedge clk) begin
		row[0] <= clamp_unit(sub_s1[0] ? 34'(t0 - ab0_s1) : 34'(ab0_s1 + t0));
		row[1] <= clamp_unit(sub_s1[1] ? 34'(-34'(a1_s1)) : ab1_s1);
		row[2] <= clamp_unit(sub_s1[2] ? 34'(t2 - ab2_s1) : 34'(ab2_s1 + t2));
		px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;
	end
	// translation
	logic signed [65:0] sum;
	logic signed [63:0] mg;
	logic [65:0] m, rq;
	logic signed [66:0] v;
	assign sum = 66'(64'(row[0]) * 64'(px_s2)) + 66'(64'(row[1]) * 64'(py_s2))
		+ 66'(64'(row[2]) * 64'(pz_s2));
	assign m = sum[65] ? 66'(-sum) : 66'(sum);
	assign rq = (m + 66'(1 << 29)) >> 30;
	assign v = sum[65] ? 67'(rq) : -67'(rq);
	assign mg = 64'(v);
	always_ff @(posedge clk) begin
		if (v > 67'sd2147483647) shift <= 32'sh7FFF_FFFF;
		else if (v < -67'sd2147483648) shift <= 32'sh8000_0000;
		else shift <= 32'(mg);
	end
endmodule

FILE: dv/euler_yxz_view_matrix_tb.sv
// Self-checking testbench for euler_yxz_view_matrix: directed rows, then random poses.
// Depends on eyvm_pkg and the euler_yxz_view_matrix RTL; expected matrices come from a local predictor.
module euler_yxz_view_matrix_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import eyvm_pkg::*;

	localparam int LATENCY = 17;
	localparam int N_RANDOM = 1430;
	localparam int N_DIRECTED = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_beat_t din = '0;
	logic busy;
	logic done;
	out_beat_t dout;

	out_beat_t pending_views[$];
	bit failed = 1'b0;

	euler_yxz_view_matrix DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.din(din), .done(done), .dout(dout)
	);

	always #4 clk = ~clk;

	// Rounded shift, ties away from zero
	function automatic longint rnd_shift(input longint p, input int sh);
		longint unsigned m;
		longint unsigned r;
		begin
			m = (p < 0) ? longint'(-p) : p;
			r = (m + (64'd1 << (sh - 1))) >> sh;
			return (p < 0) ? -longint'(r) : longint'(r);
		end
	endfunction

	function automatic longint q30mul(input longint a, input longint b);
		return rnd_shift(a * b, 30);
	endfunction

	function automatic longint to_unit(input longint v);
		if (v > (64'sd1 << 30)) return 64'sd1 << 30;
		if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
		return v;
	endfunction

	// Horner evaluation of 1 - x2/k0(1 - x2/k1(...)), outermost divisor first in list
	function automatic longint unsigned series(input longint unsigned x2, input int k0,
			input int k1, input int k2, input int k3, input int k4);
		int kk[5];
		longint unsigned t;
		longint unsigned d;
		longint unsigned q;
		begin
			kk = '{k0, k1, k2, k3, k4};
			t = 64'd1 << 30;
			for (int i = 4; i >= 0; i--) begin
				d = longint'(kk[i]) << 30;
				q = (x2 * t + d / 2) / d;
				t = (q >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - q;
			end
			return t;
		end
	endfunction

	function automatic void angle_trig(input logic [15:0] a, output longint s,
			output longint c);
		logic [1:0] quad;
		longint unsigned r;
		longint unsigned rr;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned sn;
		longint unsigned cs;
		longint s0;
		longint c0;
		bit fold;
		begin
			quad = a[15:14];
			r = a[13:0];
			fold = r > 8192;
			rr = fold ? 16384 - r : r;
			x = (rr * 64'h3243F6A88 + (64'd1 << 16)) >> 17;
			x2 = (x * x + (64'd1 << 29)) >> 30;
			sn = (x * series(x2, 6, 20, 42, 72, 110) + (64'd1 << 29)) >> 30;
			cs = series(x2, 2, 12, 30, 56, 90);
			s0 = fold ? cs : sn;
			c0 = fold ? sn : cs;
			case (quad)
				2'd0: begin s = s0; c = c0; end
				2'd1: begin s = c0; c = -s0; end
				2'd2: begin s = -s0; c = -c0; end
				default: begin s = -c0; c = s0; end
			endcase
		end
	endfunction

	function automatic logic [31:0] translation(input longint r0, input longint r1,
			input longint r2, input in_beat_t b);
		longint v;
		begin
			v = rnd_shift(-(r0 * longint'(b.pos_x) + r1 * longint'(b.pos_y)
				+ r2 * longint'(b.pos_z)), 30);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[31:0];
		end
	endfunction

	// Predicted view matrix for one camera pose
	function automatic out_beat_t view_of(input in_beat_t b);
		longint s1, c1, s2, c2, s3, c3;
		longint u[3], v[3], w[3];
		out_beat_t o;
		begin
			angle_trig(b.yaw, s1, c1);
			angle_trig(b.pitch, s2, c2);
			angle_trig(b.roll, s3, c3);
			u[0] = to_unit(q30mul(c1, c3) + q30mul(q30mul(s1, s2), s3));
			u[1] = to_unit(q30mul(c2, s3));
			u[2] = to_unit(q30mul(q30mul(c1, s2), s3) - q30mul(c3, s1));
			v[0] = to_unit(q30mul(q30mul(c3, s1), s2) - q30mul(c1, s3));
			v[1] = to_unit(q30mul(c2, c3));
			v[2] = to_unit(q30mul(q30mul(c1, c3), s2) + q30mul(s1, s3));
			w[0] = to_unit(q30mul(c2, s1));
			w[1] = to_unit(-s2);
			w[2] = to_unit(q30mul(c1, c2));
			o.right_x = u[0][31:0]; o.right_y = u[1][31:0]; o.right_z = u[2][31:0];
			o.up_x = v[0][31:0]; o.up_y = v[1][31:0]; o.up_z = v[2][31:0];
			o.fwd_x = w[0][31:0]; o.fwd_y = w[1][31:0]; o.fwd_z = w[2][31:0];
			o.shift_u = translation(u[0], u[1], u[2], b);
			o.shift_v = translation(v[0], v[1], v[2], b);
			o.shift_w = translation(w[0], w[1], w[2], b);
			return o;
		end
	endfunction

	// Directed rows: pose, and an identity flag where the basis is read off at a glance
	typedef struct {
		in_beat_t pose;
		bit identity;
	} pose_row_t;

	pose_row_t pose_table[N_DIRECTED] = '{
		'{'{32'sh0, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 16'sh0}, 1'b1},
		'{'{32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 16'sh0, 16'sh0, 16'sh0}, 1'b1},
		'{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh0, 16'sh0, 16'sh0}, 1'b1},
		'{'{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 16'sh0, 16'sh0, 16'sh0}, 1'b1},
		'{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh2000, 16'sh1000, 16'sh1000}, 1'b0},
		'{'{-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000, -16'sh8000, -16'sh8000, -16'sh8000}, 1'b0},
		'{'{32'sh0, 32'sh0, 32'sh0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0},
		'{'{32'sh1234_5678, 32'sh0, 32'sh0, 16'sh4000, 16'sh0, 16'sh0}, 1'b0},
		'{'{32'sh0, 32'sh1234_5678, 32'sh0, 16'sh0, 16'sh4000, 16'sh0}, 1'b0},
		'{'{32'sh0, 32'sh0, 32'sh1234_5678, 16'sh0, 16'sh0, -16'sh4000}, 1'b0},
		'{'{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'sh2000, 16'sh2001, 16'sh1FFF}, 1'b0},
		'{'{32'sh0, 32'sh0, 32'sh0, 16'sh1, -16'sh1, 16'sh3FFF}, 1'b0},
		'{'{32'shFFFF_FFFF, 32'sh1, 32'shFFFF, 16'sh6000, -16'sh6000, 16'shC00}, 1'b0},
		'{'{32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000, 16'sh4000, 16'sh4000, 16'sh4000}, 1'b0},
		'{'{32'sh0, 32'sh0, 32'sh0, 16'sh5555, -16'sh5555, 16'sh2AAA}, 1'b0},
		'{'{-32'sh1, 32'sh7FFF_0000, -32'sh7FFF_0000, 16'sh0, 16'sh2000, 16'sh0}, 1'b0}
	};

	// Identity basis: translation is just the negated position, rounded, saturated
	function automatic out_beat_t identity_view(input in_beat_t b);
		out_beat_t o;
		begin
			o = '0;
			o.right_x = ONE_Q30; o.up_y = ONE_Q30; o.fwd_z = ONE_Q30;
			o.shift_u = (b.pos_x == -32'sh8000_0000) ? 32'sh7FFF_FFFF : -b.pos_x;
			o.shift_v = (b.pos_y == -32'sh8000_0000) ? 32'sh7FFF_FFFF : -b.pos_y;
			o.shift_w = (b.pos_z == -32'sh8000_0000) ? 32'sh7FFF_FFFF : -b.pos_z;
			return o;
		end
	endfunction

	function automatic int gap_len();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (r < 55) return 0;
			if (r < 92) return $urandom_range(1, 3);
			return $urandom_range(10, 40);
		end
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 2)) - 16'd1;
			1: return 16'($urandom_range(0, 7) << 13);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'($signed(16'($urandom))) << 16;
			default: return $urandom;
		endcase
	endfunction

	// Issue one beat and log what it should produce; start stays high afterwards
	task automatic send_pose(input in_beat_t b, input out_beat_t exp_view);
		begin
			start <= 1'b1;
			din <= b;
			@(posedge clk);
			while (busy) @(posedge clk);
			pending_views.push_back(exp_view);
		end
	endtask

	// Result check on every strobe
	always @(posedge clk) begin
		out_beat_t exp_view;
		if (arst_n && done) begin
			if (pending_views.size() == 0) begin
				$display("%0t: unexpected result %h", $time, dout);
				failed = 1'b1;
			end else begin
				exp_view = pending_views.pop_front();
				if (dout !== exp_view) begin
					$display("%0t: view mismatch expected %h actual %h", $time, exp_view, dout);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		in_beat_t b;
		int g;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			b = pose_table[i].pose;
			send_pose(b, pose_table[i].identity ? identity_view(b) : view_of(b));
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			b.pos_x = rand_pos(); b.pos_y = rand_pos(); b.pos_z = rand_pos();
			b.yaw = rand_angle(); b.pitch = rand_angle(); b.roll = rand_angle();
			// Keep start high across bursts; idle only when a gap is drawn
			g = (i % 200 < 40) ? 0 : gap_len();
			send_pose(b, view_of(b));
			if (g != 0) begin
				start <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		start <= 1'b0;
		g = 0;
		while (pending_views.size() != 0 && g < 1000) begin
			@(posedge clk);
			g++;
		end
		repeat (LATENCY + 8) @(posedge clk);
		if (!failed && pending_views.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: euler_yxz_view_matrix.f
design/eyvm_pkg.sv
design/eyvm_sincos.sv
design/eyvm_lane.sv
design/euler_yxz_view_matrix.sv
dv/euler_yxz_view_matrix_tb.sv
